// ===== hw/rtl/switch_debounce_long_press_core_defines.svh =====
// Assertion macros shared by the switch debounce RTL.
// Depends on nothing; a module that uses these must have aclk and aresetn in scope.
`ifndef SWITCH_DEBOUNCE_LONG_PRESS_CORE_DEFINES_SVH
`define SWITCH_DEBOUNCE_LONG_PRESS_CORE_DEFINES_SVH

// Checked on every rising clock edge, and not checked while reset is held.
`define SDLP_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define SDLP_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hw/rtl/sdlp_pkg.sv =====
// Shared types and constants for the switch debounce and long press core.
// Depends on nothing; used by every module in hw/rtl.
package sdlp_pkg;

    // Width of the elapsed millisecond counter (legal range 8 to 32).
    localparam int TIME_BITS = 16;
    localparam int MS_BITS   = 16;
    localparam int CMP_W     = (TIME_BITS > MS_BITS) ? TIME_BITS : MS_BITS;

    localparam int CFG_IDX_BITS  = 8;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE_MS   = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_LONG_PRESS_MS = CFG_IDX_BITS'(1);

    localparam logic [MS_BITS-1:0] DEBOUNCE_MS_RESET   = MS_BITS'(20);
    localparam logic [MS_BITS-1:0] LONG_PRESS_MS_RESET = MS_BITS'(1000);

    typedef struct packed {
        logic [MS_BITS-1:0] debounce_ms;
        logic [MS_BITS-1:0] long_press_ms;
    } cfg_t;

    typedef struct packed {
        logic switch_level;
        logic ack_pressed;
    } tick_t;

    typedef struct packed {
        logic is_down;
        logic is_long_press;
        logic short_press_event;
    } result_t;

endpackage

// ===== hw/rtl/sdlp_cfg_regs.sv =====
// Configuration registers: debounce time and long press limit.
// Depends on sdlp_pkg.
module sdlp_cfg_regs
    import sdlp_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ms   <= DEBOUNCE_MS_RESET;
            cfg_reg.long_press_ms <= LONG_PRESS_MS_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_DEBOUNCE_MS:   cfg_reg.debounce_ms   <= cfg_data[MS_BITS-1:0];
                REG_LONG_PRESS_MS: cfg_reg.long_press_ms <= cfg_data[MS_BITS-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== hw/rtl/sdlp_tick_core.sv =====
// Debounce state and the per-tick update: elapsed counter, level and press flag.
// Depends on sdlp_pkg.
module sdlp_tick_core
    import sdlp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step_en,
    input  cfg_t    cfg,
    input  tick_t   tick,
    output result_t result
);

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    logic                 stable_level_reg, stable_level_next;
    logic                 raw_level_reg, raw_level_next;
    logic                 level_valid_reg, level_valid_next;
    logic [TIME_BITS-1:0] elapsed_ms_reg, elapsed_ms_next;
    logic                 press_flag_reg, press_flag_next;

    logic [TIME_BITS-1:0] elapsed_inc;
    logic                 flag_report;
    logic [CMP_W-1:0]     inc_x, elapsed_x, debounce_x, long_x;

    assign debounce_x = CMP_W'(cfg.debounce_ms);
    assign long_x     = CMP_W'(cfg.long_press_ms);
    assign inc_x      = CMP_W'(elapsed_inc);

    always_comb begin
        elapsed_inc = (elapsed_ms_reg != TIME_MAX) ? elapsed_ms_reg + 1'b1 : elapsed_ms_reg;

        stable_level_next = stable_level_reg;
        raw_level_next    = raw_level_reg;
        level_valid_next  = level_valid_reg;
        elapsed_ms_next   = elapsed_inc;
        flag_report       = press_flag_reg;

        if (tick.switch_level != raw_level_reg) begin
            if (level_valid_reg) begin
                // A release that ends a stable press reports whether it was short.
                if (!tick.switch_level && stable_level_reg) begin
                    flag_report = (inc_x < long_x);
                end
                if (tick.switch_level != stable_level_reg) begin
                    level_valid_next = 1'b0;
                end
            end
            if (!level_valid_next) begin
                elapsed_ms_next = '0;
                raw_level_next  = tick.switch_level;
            end
        end

        elapsed_x = CMP_W'(elapsed_ms_next);
        if (!level_valid_next && (elapsed_x > debounce_x)) begin
            stable_level_next = raw_level_next;
            level_valid_next  = 1'b1;
        end

        result.is_down           = stable_level_next;
        result.is_long_press     = stable_level_next && level_valid_next && (elapsed_x > long_x);
        result.short_press_event = flag_report;

        press_flag_next = tick.ack_pressed ? 1'b0 : flag_report;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_level_reg <= 1'b0;
            raw_level_reg    <= 1'b0;
            level_valid_reg  <= 1'b1;
            elapsed_ms_reg   <= '0;
            press_flag_reg   <= 1'b0;
        end else if (step_en) begin
            stable_level_reg <= stable_level_next;
            raw_level_reg    <= raw_level_next;
            level_valid_reg  <= level_valid_next;
            elapsed_ms_reg   <= elapsed_ms_next;
            press_flag_reg   <= press_flag_next;
        end
    end

endmodule

// ===== hw/rtl/switch_debounce_long_press_core.sv =====
// Push button debouncer with short and long press detection. Each input word is
// one millisecond tick (switch level and an acknowledge for the short press flag)
// and produces exactly one result word. The block takes one word per clock cycle
// and only stalls while a full result register waits on m_tready. A result word
// is presented on m_tvalid once its tick has moved from the input register into
// the result register; that move waits while the result register is full and not
// drained. The per-tick update is a single increment and a few compares on the
// 16-bit elapsed counter. Configuration registers may be written only while no
// tick is in flight.
// Depends on sdlp_pkg, sdlp_cfg_regs, sdlp_tick_core and the defines header.
`include "switch_debounce_long_press_core_defines.svh"

module switch_debounce_long_press_core
    import sdlp_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    // Tick input.
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [7:0]               s_tdata,   // [0] switch_level, [1] ack_pressed, rest zero
    // Result output.
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [7:0]               m_tdata,   // [0] is_down, [1] is_long_press,
                                                // [2] short_press_event, rest zero
    // Configuration write channel.
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    cfg_t    cfg;
    tick_t   in_tick_reg;
    logic    in_valid_reg;
    logic    out_valid_reg;
    result_t out_result_reg;
    result_t step_result;
    logic    advance;

    sdlp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sdlp_tick_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .cfg     (cfg),
        .tick    (in_tick_reg),
        .result  (step_result)
    );

    // A word moves from the input register to the result register when the
    // result register is empty or is being drained this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_tick_reg.switch_level <= s_tdata[0];
            in_tick_reg.ack_pressed  <= s_tdata[1];
        end
        if (advance) begin
            out_result_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_result_reg.short_press_event,
                       out_result_reg.is_long_press, out_result_reg.is_down};

    `SDLP_ASSERT(a_advance_fills_output, advance |=> out_valid_reg, "advanced word missing")
    `SDLP_ASSERT(a_stalled_input_kept, (in_valid_reg && !advance) |=> in_valid_reg, "stalled tick lost")
    `SDLP_ASSERT(a_long_implies_down, out_valid_reg |-> (!out_result_reg.is_long_press || out_result_reg.is_down), "long while up")
    `SDLP_ASSERT_ALWAYS(a_reset_empties, !aresetn |=> (!in_valid_reg && !out_valid_reg), "not empty after reset")

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for switch_debounce_long_press_core: millisecond ticks go in on the
// s_ stream, one result word per tick comes back on the m_ stream, checked against a predictor.
// Depends on sdlp_pkg and the core RTL in hw/rtl.
module testbench;
    import sdlp_pkg::*;

    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = '1;

    typedef enum bit {ROW_TICK, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t                 kind;
        logic [CFG_IDX_BITS-1:0]   idx;
        logic [CFG_DATA_BITS-1:0]  val;
        bit                        level;
        bit                        ack;
        int unsigned               reps;
        bit                        typed;
        result_t                   want;    // {is_down, is_long_press, short_press_event}
    } row_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [7:0]               s_tdata;      // [0] switch_level, [1] ack_pressed, rest zero
    logic                     m_tvalid;
    logic                     m_tready;
    logic [7:0]               m_tdata;      // [0] is_down, [1] is_long_press,
                                            // [2] short_press_event, rest zero
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    // Predictor state and its copy of the registers.
    logic [MS_BITS-1:0]   debounce_limit;
    logic [MS_BITS-1:0]   long_limit;
    bit                   btn_stable;
    bit                   btn_raw;
    bit                   btn_valid;
    logic [TIME_BITS-1:0] btn_elapsed;
    bit                   btn_flag;

    result_t     button_outputs_q[$];
    bit          idle_en;
    int          stall_left;
    int unsigned mismatches;
    int unsigned ticks_sent;
    int unsigned settings_run;
    int unsigned short_seen;
    int unsigned long_seen;

    // Directed script; expectations are typed in only for the words right after reset.
    row_t script [29] = '{
        //  kind       idx                val       lvl  ack  reps      typed want
        '{ROW_TICK,  REG_UNUSED,        16'h0000, 1'b0, 1'b0, 3,     1'b1, 3'b000},
        '{ROW_TICK,  REG_UNUSED,        16'h0000, 1'b0, 1'b1, 1,     1'b1, 3'b000},
        '{ROW_TICK,  REG_UNUSED,        16'h0000, 1'b1, 1'b0, 5,     1'b1, 3'b000},
        '{ROW_WRITE, REG_DEBOUNCE_MS,   16'h0000, 1'b0, 1'b0, 0,     1'b0, 3'b000},
        '{ROW_WRITE, REG_LONG_PRESS_MS, 16'h0000, 1'b0, 1'b0, 0,     1'b0, 3'b000},
        '{ROW_TICK,  REG_UNUSED,        16'h0000, 1'b1, 1'b0, 3,     1'b0, 3'b000},
        '{ROW_TICK,  REG_UNUSED,        16'h0000, 1'b0, 1'b0, 2,     1'b0, 3'b000},
        '{ROW_WRITE, REG_LONG_PRESS_MS, 16'h0005, 1'b0, 1'b0, 0,     1'b0, 3'b000},
        '{ROW_TICK,  REG_UNUSED,        16'h0000, 1'b1, 1'b0, 3,     1'b0, 3'b000},
        '{ROW_TICK,  REG_UNUSED,        16'h0000, 1'b0, 1'b0, 2,     1'b0, 3'b000},
        '{ROW_TICK,  REG_UNUSED,        16'h0000, 1'b0, 1'b0, 3,     1'b0, 3'b000},
        '{ROW_TICK,  REG_UNUSED,        16'h0000, 1'b0, 1'b1, 1,     1'b0, 3'b000},
        '{ROW_TICK,  REG_UNUSED,        16'h0000, 1'b0, 1'b0, 1,     1'b0, 3'b000},
        '{ROW_WRITE, REG_DEBOUNCE_MS,   16'hFFFF, 1'b0, 1'b0, 0,     1'b0, 3'b000},
        '{ROW_WRITE, REG_LONG_PRESS_MS, 16'hFFFF, 1'b0, 1'b0, 0,     1'b0, 3'b000},
        '{ROW_TICK,  REG_UNUSED,        16'h0000, 1'b1, 1'b1, 4,     1'b0, 3'b000},
        '{ROW_TICK,  REG_UNUSED,        16'h0000, 1'b0, 1'b0, 2,     1'b0, 3'b000},
        '{ROW_WRITE, REG_UNUSED,        16'h1234, 1'b0, 1'b0, 0,     1'b0, 3'b000},
        '{ROW_WRITE, REG_DEBOUNCE_MS,   16'h0003, 1'b0, 1'b0, 0,     1'b0, 3'b000},
        '{ROW_TICK,  REG_UNUSED,        16'h0000, 1'b0, 1'b0, 6,     1'b0, 3'b000},
        '{ROW_TICK,  REG_UNUSED,        16'h0000, 1'b1, 1'b0, 1,     1'b0, 3'b000},
        '{ROW_TICK,  REG_UNUSED,        16'h0000, 1'b0, 1'b0, 1,     1'b0, 3'b000},
        '{ROW_TICK,  REG_UNUSED,        16'h0000, 1'b1, 1'b0, 8,     1'b0, 3'b000},
        '{ROW_TICK,  REG_UNUSED,        16'h0000, 1'b0, 1'b0, 8,     1'b0, 3'b000},
        // A hold past the counter's top end: it must stay long and read as not short.
        '{ROW_WRITE, REG_DEBOUNCE_MS,   16'h0000, 1'b0, 1'b0, 0,     1'b0, 3'b000},
        '{ROW_WRITE, REG_LONG_PRESS_MS, 16'hFFFE, 1'b0, 1'b0, 0,     1'b0, 3'b000},
        '{ROW_TICK,  REG_UNUSED,        16'h0000, 1'b1, 1'b0, 70000, 1'b0, 3'b000},
        '{ROW_TICK,  REG_UNUSED,        16'h0000, 1'b0, 1'b0, 3,     1'b0, 3'b000},
        '{ROW_TICK,  REG_UNUSED,        16'h0000, 1'b0, 1'b1, 1,     1'b0, 3'b000}
    };

    switch_debounce_long_press_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(60_000_000);
        $display("switch_debounce_long_press_core regression: fail");
        $finish;
    end

    // One millisecond of button behavior: returns the outputs for this tick.
    function automatic result_t advance_button_ms(bit level, bit ack);
        result_t r;
        if (btn_elapsed != '1) btn_elapsed = btn_elapsed + 1'b1;
        if (level != btn_raw) begin
            if (btn_valid) begin
                if (!level && btn_stable) btn_flag = (btn_elapsed < long_limit);
                if (level != btn_stable) btn_valid = 1'b0;
            end
            if (!btn_valid) begin
                btn_elapsed = '0;
                btn_raw = level;
            end
        end
        if (!btn_valid && btn_elapsed > debounce_limit) begin
            btn_stable = btn_raw;
            btn_valid = 1'b1;
        end
        r.is_down = btn_stable;
        r.is_long_press = btn_stable && btn_valid && (btn_elapsed > long_limit);
        r.short_press_event = btn_flag;
        if (ack) btn_flag = 1'b0;
        return r;
    endfunction

    task automatic send_tick(input bit level, input bit ack, input bit typed, input result_t want);
        result_t predicted;
        if (idle_en && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'b0, ack, level};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = advance_button_ms(level, ack);
        button_outputs_q.push_back(typed ? want : predicted);
        ticks_sent++;
    endtask

    // Stops the sender and waits until every expected word has come back.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (button_outputs_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == REG_DEBOUNCE_MS) debounce_limit = val;
        else if (idx == REG_LONG_PRESS_MS) long_limit = val;
        settings_run++;
    endtask

    // Mostly presses and releases held past the debounce time (or past 40 ms when it is
    // longer), with contact bounce and repeated levels mixed in.
    task automatic random_phase(input logic [MS_BITS-1:0] deb, input logic [MS_BITS-1:0] lng,
                                input int unsigned count, input bit pause_mid);
        int unsigned sent;
        int unsigned run;
        int unsigned base;
        int unsigned span;
        int unsigned k;
        bit lvl;
        write_reg(REG_DEBOUNCE_MS, deb);
        write_reg(REG_LONG_PRESS_MS, lng);
        base = (deb > 40) ? 40 : deb;
        span = (lng > 60) ? 60 : lng;
        lvl = btn_raw;
        sent = 0;
        while (sent < count) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    run = $urandom_range(1, 3);
                    lvl = ~lvl;
                end
                3: run = $urandom_range(1, 5);
                default: begin
                    run = base + 1 + $urandom_range(0, span + 3);
                    lvl = ~lvl;
                end
            endcase
            for (k = 0; k < run && sent < count; k++) begin
                send_tick(lvl, $urandom_range(0, 3) == 0, 1'b0, '0);
                sent++;
                if (pause_mid && sent == count / 2) wait_idle();
            end
        end
    endtask

    always @(posedge aclk) begin
        if (stall_left > 0) stall_left--;
        else if (idle_en && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 7);
        m_tready <= (stall_left == 0);
    end

    always @(posedge aclk) begin : result_check
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.is_down = m_tdata[0];
            got.is_long_press = m_tdata[1];
            got.short_press_event = m_tdata[2];
            if (got.is_long_press) long_seen++;
            if (got.short_press_event) short_seen++;
            if (button_outputs_q.size() == 0) begin
                $error("result word arrived with no tick waiting for it");
                mismatches++;
            end else begin
                want = button_outputs_q.pop_front();
                if (got.is_down !== want.is_down) begin
                    $error("is_down: expected %0b, actual %0b", want.is_down, got.is_down);
                    mismatches++;
                end
                if (got.is_long_press !== want.is_long_press) begin
                    $error("is_long_press: expected %0b, actual %0b",
                           want.is_long_press, got.is_long_press);
                    mismatches++;
                end
                if (got.short_press_event !== want.short_press_event) begin
                    $error("short_press_event: expected %0b, actual %0b",
                           want.short_press_event, got.short_press_event);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        int unsigned r;
        int unsigned k;
        int unsigned guard;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        m_tready = 1'b1;
        stall_left = 0;
        idle_en = 1'b1;
        mismatches = 0;
        ticks_sent = 0;
        settings_run = 0;
        short_seen = 0;
        long_seen = 0;
        debounce_limit = DEBOUNCE_MS_RESET;
        long_limit = LONG_PRESS_MS_RESET;
        btn_stable = 1'b0;
        btn_raw = 1'b0;
        btn_valid = 1'b1;
        btn_elapsed = '0;
        btn_flag = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (r = 0; r < $size(script); r++) begin
            if (script[r].kind == ROW_WRITE) begin
                write_reg(script[r].idx, script[r].val);
            end else begin
                for (k = 0; k < script[r].reps; k++)
                    send_tick(script[r].level, script[r].ack, script[r].typed, script[r].want);
            end
        end

        random_phase(16'd2, 16'd10, 250, 1'b1);
        random_phase(16'd0, 16'd0, 150, 1'b0);
        random_phase(16'd5, 16'd30, 250, 1'b0);
        random_phase(16'd1, 16'hFFFF, 150, 1'b0);
        random_phase(16'hFFFF, 16'd0, 60, 1'b0);
        random_phase(16'($urandom_range(0, 8)), 16'($urandom_range(0, 40)), 250, 1'b0);
        idle_en = 1'b0;
        random_phase(16'd3, 16'd12, 300, 1'b0);

        s_tvalid <= 1'b0;
        guard = 0;
        while (button_outputs_q.size() != 0 && guard < 1000) begin
            @(posedge aclk);
            guard++;
        end
        if (button_outputs_q.size() != 0) begin
            $error("%0d expected result words never arrived", button_outputs_q.size());
            mismatches++;
        end
        repeat (8) @(posedge aclk);

        $display("Ran %0d ticks through %0d register writes, long holds past counter saturation.",
                 ticks_sent, settings_run);
        $display("Saw %0d words flagging a short press and %0d reporting a long press.",
                 short_seen, long_seen);
        if (mismatches == 0) begin
            $display("switch_debounce_long_press_core regression: pass");
        end else begin
            $display("switch_debounce_long_press_core regression: fail");
        end
        $finish;
    end
endmodule

// ===== switch_debounce_long_press_core.f =====
+incdir+hw/rtl
hw/rtl/sdlp_pkg.sv
hw/rtl/sdlp_cfg_regs.sv
hw/rtl/sdlp_tick_core.sv
hw/rtl/switch_debounce_long_press_core.sv
tb/sv/testbench.sv
